// ===== sv/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, reset values and the entry type held in each cell.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Fixed widths of the request and response fields.
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;

  // Default depth of the cell chain and reset value of the capacity register.
  localparam int              EntriesDefault = 16;
  localparam logic [CapW-1:0] CapReset       = CapW'(16);

  // Operation codes on the request channel.
  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  // One stored pair plus its valid flag.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lkvc_entry_t;

endpackage

// ===== sv/lkvc_req_if.sv =====
// ----------------------------------------------------------------------------
// LRU cache request channel
// Valid/ready channel carrying one get or put word.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

// ===== sv/lkvc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// LRU cache response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;
  logic               evicted;

  modport source (output valid, output found, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input found, input read_value, input evicted,
                  output ready);
endinterface

// ===== sv/lkvc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// LRU cache configuration channel
// Valid/ready write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lkvc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

// ===== sv/lkvc_cell.sv =====
// ----------------------------------------------------------------------------
// LRU cache cell
// Holds one entry at a fixed recency position, compares it against the
// broadcast key and loads its neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  lkvc_pkg::lkvc_entry_t        prev_i,
  input  logic [lkvc_pkg::KeyW-1:0]    key_i,
  output lkvc_pkg::lkvc_entry_t        entry_o,
  output logic                         hit_o
);
  import lkvc_pkg::*;

  logic            valid_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;

  // The valid flag is control state and is cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= prev_i.valid;
    end
  end

  // Key and value follow the valid flag down the chain.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  // Lookup compare against the broadcast key.
  assign hit_o   = valid_q && (key_q == key_i);
  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative store kept as a chain of cells ordered by recency.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one word per operation: cmd (get or put), key and value.
//   rsp_o returns one word per request: found, read_value and evicted.
//   cfg_i writes the capacity register; it is always ready and should be
//   written only while no request is outstanding.
// Cell 0 holds the most recent entry, and valid cells always form a prefix
// of the chain. A lookup compares the key in every cell at once; a hit or a
// put then shifts the cells in front of the affected position down by one
// and loads the entry into cell 0, all in the accepting cycle.
// The response is registered and appears in the cycle after the request is
// accepted; a new request is accepted every cycle while the response register
// is empty or its word is being taken.
// Reset empties the store and sets the capacity to 16. When the receiver
// stalls, the response register holds its word and req_i.ready drops until
// that word is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int ENTRIES = lkvc_pkg::EntriesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  lkvc_req_if.sink   req_i,
  lkvc_rsp_if.source rsp_o,
  lkvc_cfg_if.sink   cfg_i
);
  import lkvc_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OccW = $clog2(ENTRIES + 1);
  localparam int CmpW = (OccW > CapW) ? OccW : CapW;

  logic [CapW-1:0] capacity_q;
  logic [OccW-1:0] occ_q, occ_d;
  logic            rsp_valid_q;
  logic            found_q, evicted_q;
  logic [ValW-1:0] read_value_q;

  lkvc_entry_t       cell_entry [ENTRIES];
  lkvc_entry_t       cell_prev  [ENTRIES];
  lkvc_entry_t       head_entry;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] shift_vec;

  logic            accept;
  logic            any_hit;
  logic [IdxW-1:0] hit_idx;
  logic [ValW-1:0] hit_value;
  logic [CmpW-1:0] cap_eff;
  logic            evict_need;
  logic            miss_put;
  logic            update;
  logic [IdxW-1:0] stop_idx;

  // Handshakes.
  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      capacity_q <= cfg_i.capacity;
    end
  end

  // Effective capacity: zero acts as one, anything above the depth as the depth.
  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = CmpW'(1);
    end else if (CmpW'(capacity_q) > CmpW'(ENTRIES)) begin
      cap_eff = CmpW'(ENTRIES);
    end else begin
      cap_eff = CmpW'(capacity_q);
    end
  end

  assign evict_need = CmpW'(occ_q) >= cap_eff;

  // The cell chain.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_prev[g] = head_entry;
    end else begin : g_link
      assign cell_prev[g] = cell_entry[g-1];
    end

    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_vec[g]),
      .prev_i  (cell_prev[g]),
      .key_i   (req_i.key),
      .entry_o (cell_entry[g]),
      .hit_o   (hit_vec[g])
    );

    assign valid_vec[g] = cell_entry[g].valid;
    assign shift_vec[g] = update && (IdxW'(g) <= stop_idx);
  end

  // Hit position and hit value; at most one cell can match.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx   = hit_idx | IdxW'(i);
        hit_value = hit_value | cell_entry[i].value;
      end
    end
  end

  assign any_hit  = |hit_vec;
  assign miss_put = (req_i.cmd == CmdPut) && !any_hit;
  assign update   = accept && (any_hit || (req_i.cmd == CmdPut));

  // Last cell that takes its neighbor's entry: the hit cell, the last valid
  // cell when the oldest entry falls off, or the first free cell otherwise.
  always_comb begin
    if (any_hit) begin
      stop_idx = hit_idx;
    end else if (evict_need) begin
      stop_idx = IdxW'(occ_q - OccW'(1));
    end else begin
      stop_idx = IdxW'(occ_q);
    end
  end

  // The entry loaded into cell 0 becomes the most recent one.
  always_comb begin
    head_entry.valid = 1'b1;
    head_entry.key   = req_i.key;
    head_entry.value = (req_i.cmd == CmdPut) ? req_i.value : hit_value;
  end

  // Occupancy grows only on an insert that evicts nothing.
  always_comb begin
    occ_d = occ_q;
    if (accept && miss_put && !evict_need) begin
      occ_d = occ_q + OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q      <= any_hit;
      read_value_q <= (any_hit && (req_i.cmd == CmdGet)) ? hit_value : '0;
      evicted_q    <= miss_put && evict_need;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.read_value = read_value_q;
  assign rsp_o.evicted    = evicted_q;

`ifndef SYNTHESIS
  // Keys are unique among valid cells, so a lookup matches at most one cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_vec))
    else $error("lookup matched more than one cell");

  // Valid cells form an unbroken prefix of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + ENTRIES'(1)) & valid_vec) == '0)
    else $error("valid cells are not contiguous from cell 0");

  // The occupancy count matches the number of valid cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(occ_q))
    else $error("occupancy count disagrees with valid cells");

  // A get never changes the occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.cmd == CmdGet) |=> $stable(occ_q))
    else $error("get changed the occupancy");

  // An eviction only happens on a put that missed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && evicted_q |-> !found_q && (read_value_q == '0))
    else $error("eviction reported together with a hit");
`endif

endmodule
